@@ hw/rtl/smac_pkg.sv @@
package smac_pkg;

   // field widths of the stream words
   localparam int KIND_W   = 2;
   localparam int ADDR_W   = 15;
   localparam int LEN_W    = 6;
   localparam int STATUS_W = 2;

   // shadow geometry
   localparam int GRANULE_LOG2       = 3;
   localparam int GIDX_W             = ADDR_W - GRANULE_LOG2;
   localparam int END_W              = ADDR_W + 1;
   localparam int STOP_W             = END_W - GRANULE_LOG2;
   localparam int REDZONE_BYTES      = 32;
   localparam int SHADOW_ENTRIES_DEF = 4096;
   localparam int SIZE_W             = 4;
   localparam int CNT_W              = 3;

   localparam logic [7:0] POISON_BYTE = 8'hFF;
   localparam logic [7:0] CLEAN_BYTE  = 8'h00;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STORE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POISON   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNPOISON = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ILLEGAL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd2;

   // decoded operations handed to the back end
   localparam logic [1:0] OP_CHECK = 2'd0;
   localparam logic [1:0] OP_RANGE = 2'd1;
   localparam logic [1:0] OP_BAD   = 2'd2;

   typedef struct packed {
      logic [1:0]        op;
      logic [GIDX_W-1:0] idx;        // first granule
      logic [2:0]        off;        // byte offset inside granule
      logic [SIZE_W-1:0] size;       // effective check size
      logic [7:0]        first_val;  // shadow value for first granule
      logic [7:0]        fill_val;   // shadow value for later granules
      logic [CNT_W-1:0]  count;      // granules after the first
   } cmd_type;

endpackage

@@ hw/rtl/smac_ram.sv @@
module smac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/smac_front.sv @@
module smac_front import smac_pkg::*; #(
   parameter int SHADOW_ENTRIES = SHADOW_ENTRIES_DEF
) (
   input  logic [KIND_W-1:0] kind,
   input  logic [ADDR_W-1:0] address,
   input  logic [LEN_W-1:0]  length,
   output cmd_type           cmd
);

   localparam int ENT_W = $clog2(SHADOW_ENTRIES + 1);
   localparam int CMP_W = (ENT_W > STOP_W) ? ENT_W : STOP_W;
   localparam logic [CMP_W-1:0] ENT_LIM = CMP_W'(SHADOW_ENTRIES);
   localparam logic [LEN_W:0]   LEN_LIM = (LEN_W + 1)'(2 * REDZONE_BYTES);

   logic [GIDX_W-1:0] first;
   logic [2:0]        off;
   logic [END_W-1:0]  end_addr;
   logic [STOP_W-1:0] stop;
   logic [STOP_W-1:0] span_m1;
   logic              bad_size;
   logic              bad_idx;
   logic              bad_range;
   logic              is_poison;
   logic              load_word;

   assign first    = address[ADDR_W-1:GRANULE_LOG2];
   assign off      = address[GRANULE_LOG2-1:0];
   assign end_addr = END_W'(address) + END_W'(length);
   assign stop     = end_addr[END_W-1:GRANULE_LOG2];
   assign span_m1  = stop - STOP_W'(first) - STOP_W'(1);

   // check legality
   assign bad_size = !(length == LEN_W'(1) || length == LEN_W'(2) ||
                       length == LEN_W'(4) || length == LEN_W'(8));
   assign bad_idx  = CMP_W'(first) >= ENT_LIM;

   // range legality: nonempty, short, aligned end, inside region
   assign bad_range = (length == '0) || ({1'b0, length} >= LEN_LIM) ||
                      (end_addr[GRANULE_LOG2-1:0] != '0) ||
                      (CMP_W'(stop) > ENT_LIM);

   assign is_poison = (kind == KIND_POISON);
   // aligned 4-byte load is checked as one byte
   assign load_word = (kind == KIND_LOAD) && (length == LEN_W'(4)) &&
                      (address[1:0] == 2'b00);

   always_comb begin
      cmd.idx       = first;
      cmd.off       = off;
      cmd.size      = load_word ? SIZE_W'(1) : length[SIZE_W-1:0];
      cmd.first_val = CLEAN_BYTE;
      cmd.fill_val  = is_poison ? POISON_BYTE : CLEAN_BYTE;
      cmd.count     = span_m1[CNT_W-1:0];
      cmd.op        = OP_BAD;
      if (is_poison) begin
         cmd.first_val = (off == 3'd0) ? POISON_BYTE : {5'd0, off};
      end
      case (kind)
         KIND_LOAD, KIND_STORE: begin
            cmd.op = (bad_size || bad_idx) ? OP_BAD : OP_CHECK;
         end
         KIND_POISON, KIND_UNPOISON: begin
            cmd.op = bad_range ? OP_BAD : OP_RANGE;
         end
         default: begin
            cmd.op = OP_BAD;
         end
      endcase
   end

endmodule

@@ hw/rtl/smac_queue.sv @@
module smac_queue import smac_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hw/rtl/smac_back.sv @@
module smac_back import smac_pkg::*; #(
   parameter int SHADOW_ENTRIES = SHADOW_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  cmd_type                           cmd,
   output logic                              clearing,
   output logic                              ram_wr_en,
   output logic [$clog2(SHADOW_ENTRIES)-1:0] ram_wr_addr,
   output logic [7:0]                        ram_wr_data,
   output logic                              ram_rd_en,
   output logic [$clog2(SHADOW_ENTRIES)-1:0] ram_rd_addr,
   input  logic [7:0]                        ram_rd_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [STATUS_W-1:0]               rsp_status
);

   localparam int AW = $clog2(SHADOW_ENTRIES);
   localparam logic [AW-1:0] LAST_ENTRY = AW'(SHADOW_ENTRIES - 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_FILL = 2'd2;
   localparam logic [1:0] S_HOLD = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic                clr_ff, clr_in;
   logic [AW-1:0]       clr_cnt_ff, clr_cnt_in;
   cmd_type             cur_ff, cur_in;
   logic [AW-1:0]       fill_addr_ff, fill_addr_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic [STATUS_W-1:0] hold_st_ff, hold_st_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                out_free;
   logic                done;
   logic [STATUS_W-1:0] done_st;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [7:0]          wr_data;
   logic [4:0]          reach;
   logic                chk_fail;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == S_IDLE) && !clr_ff;
   assign clearing  = clr_ff;

   // shadow check on the word just read
   assign reach = {2'b00, cur_ff.off} + {1'b0, cur_ff.size};
   always_comb begin
      if (cur_ff.size == SIZE_W'(8)) begin
         chk_fail = (ram_rd_data != 8'd0);
      end else begin
         chk_fail = (ram_rd_data != 8'd0) &&
                    ($signed({4'b0000, reach}) > $signed({ram_rd_data[7], ram_rd_data}));
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      fill_addr_in = fill_addr_ff;
      left_in      = left_ff;
      hold_st_in   = hold_st_ff;
      done         = 1'b0;
      done_st      = ST_OK;
      wr_en        = 1'b0;
      wr_addr      = fill_addr_ff;
      wr_data      = cur_ff.fill_val;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = AW'(cmd.idx);
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !clr_ff) begin
               cur_in = cmd;
               case (cmd.op)
                  OP_CHECK: begin
                     ram_rd_en = 1'b1;
                     state_in  = S_READ;
                  end
                  OP_RANGE: begin
                     wr_en        = 1'b1;
                     wr_addr      = AW'(cmd.idx);
                     wr_data      = cmd.first_val;
                     fill_addr_in = AW'(cmd.idx) + AW'(1);
                     left_in      = cmd.count;
                     if (cmd.count == '0) begin
                        done = 1'b1;
                     end else begin
                        state_in = S_FILL;
                     end
                  end
                  default: begin
                     done    = 1'b1;
                     done_st = ST_MALFORMED;
                  end
               endcase
            end
         end
         S_READ: begin
            done    = 1'b1;
            done_st = chk_fail ? ST_ILLEGAL : ST_OK;
         end
         S_FILL: begin
            wr_en        = 1'b1;
            fill_addr_in = fill_addr_ff + AW'(1);
            left_in      = left_ff - CNT_W'(1);
            if (left_ff == CNT_W'(1)) begin
               done = 1'b1;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // hand the status to the output word, or park it
      if (done) begin
         if (out_free) begin
            state_in = S_IDLE;
         end else begin
            hold_st_in = done_st;
            state_in   = S_HOLD;
         end
      end
   end

   // output word
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      if (done && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = done_st;
      end else if (state_ff == S_HOLD && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = hold_st_ff;
      end
   end

   // clearing pass after reset
   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == LAST_ENTRY) begin
            clr_in = 1'b0;
         end
      end
   end

   assign ram_wr_en   = clr_ff || wr_en;
   assign ram_wr_addr = clr_ff ? clr_cnt_ff : wr_addr;
   assign ram_wr_data = clr_ff ? CLEAN_BYTE : wr_data;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clr_ff       <= 1'b1;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      fill_addr_ff  <= fill_addr_in;
      left_ff       <= left_in;
      hold_st_ff    <= hold_st_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

@@ hw/rtl/shadow_memory_access_checker.sv @@
// Shadow memory access checker.
// One shadow byte per 8-byte granule: 0 whole granule valid, 1..7 only the
// first k bytes valid, 0xFF poisoned.
// req channel: one word per request; kind in tuser (load check, store check,
// poison range, unpoison range), address and length in tdata.
// rsp channel: exactly one status word per request, in request order.
// A front end decodes and validates each request into a two-entry command
// queue; the back end walks the shadow RAM (one port write, one registered
// read) and drives a registered output word.
// Back end, per request: a check reads the RAM, then compares; poison and
// unpoison write 1 to 8 granules in turn; a malformed one just gets a status.
// Reset: a clearing pass zeroes all SHADOW_ENTRIES shadow bytes; req_tready
// stays low until it ends.
// When rsp_tready is low the finished status stays parked; the queue keeps
// taking up to two more requests before req_tready drops.
module shadow_memory_access_checker import smac_pkg::*; #(
   parameter int SHADOW_ENTRIES = SHADOW_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,   // address[14:0], length[20:15], zero pad
   input  logic [KIND_W-1:0] req_tuser,   // kind[1:0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata    // status[1:0], zero pad
);

   localparam int AW    = $clog2(SHADOW_ENTRIES);
   localparam int ENT_W = $clog2(SHADOW_ENTRIES + 1);
   localparam logic [ENT_W-1:0] ENT_LIM = ENT_W'(SHADOW_ENTRIES);

   cmd_type             front_cmd;
   cmd_type             q_cmd;
   logic                q_push_ready;
   logic                q_pop_valid;
   logic                q_pop_ready;
   logic                clearing;
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [7:0]          ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [7:0]          ram_rd_data;
   logic [STATUS_W-1:0] rsp_status;

   // decode and validate
   smac_front #(
      .SHADOW_ENTRIES(SHADOW_ENTRIES)
   ) u_front (
      .kind    (req_tuser),
      .address (req_tdata[ADDR_W-1:0]),
      .length  (req_tdata[ADDR_W+LEN_W-1:ADDR_W]),
      .cmd     (front_cmd)
   );

   assign req_tready = q_push_ready && !clearing;

   smac_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid && !clearing),
      .push_ready (q_push_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_cmd    (q_cmd)
   );

   smac_back #(
      .SHADOW_ENTRIES(SHADOW_ENTRIES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (q_pop_valid),
      .cmd_ready   (q_pop_ready),
      .cmd         (q_cmd),
      .clearing    (clearing),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_status  (rsp_status)
   );

   smac_ram #(
      .WIDTH (8),
      .DEPTH (SHADOW_ENTRIES)
   ) u_shadow (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tdata = {6'd0, rsp_status};

   // no response or queued command can exist while the shadow is being cleared
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_tvalid && !q_pop_valid)
      else $error("response or command present during clearing pass");

   // shadow writes stay inside the region
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> ENT_W'(ram_wr_addr) < ENT_LIM)
      else $error("shadow write outside region");

   // shadow reads stay inside the region
   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> ENT_W'(ram_rd_addr) < ENT_LIM)
      else $error("shadow read outside region");

   // only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_status == ST_OK || rsp_status == ST_ILLEGAL ||
                      rsp_status == ST_MALFORMED))
      else $error("undefined status code");

endmodule
